### hdl/spts_pkg.sv
// Shared types and constants of the slotted page tuple store.
// Holds the operation and status codes, the transaction payloads and the controller states.
// No dependencies.
package spts_pkg;

	// Page layout constants
	localparam int HEAD_BYTES = 64;
	localparam int TAIL_BYTES = 4;
	localparam int SLOT_BYTES = 16;
	localparam int PAGE_LIMIT_RESET = 4096;

	typedef enum logic [2:0] {
		OP_INIT      = 3'd0,
		OP_PUT_START = 3'd1,
		OP_PUT_BYTE  = 3'd2,
		OP_GET       = 3'd3,
		OP_REMOVE    = 3'd4
	} spts_op_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_BADSLOT = 2'd2;
	localparam logic [1:0] STAT_BADLEN  = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  slot_index;
		logic [11:0] tuple_length;
		logic [11:0] byte_index;
		logic [7:0]  data_byte;
	} spts_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot_number;
		logic [11:0] length_out;
		logic [7:0]  byte_out;
	} spts_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOT_RD,
		S_EXEC,
		S_PAGE_RD,
		S_RESULT
	} spts_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} spts_cmd_t;

endpackage

### hdl/spts_req_if.sv
// Request channel of the slotted page tuple store.
// Carries valid, ready and the request payload; depends on spts_pkg.
interface spts_req_if
	import spts_pkg::*;
();
	logic      valid;
	logic      ready;
	spts_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/spts_rsp_if.sv
// Response channel of the slotted page tuple store.
// Carries valid, ready and the response payload; depends on spts_pkg.
interface spts_rsp_if
	import spts_pkg::*;
();
	logic      valid;
	logic      ready;
	spts_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/spts_ctrl.sv
// Controller of the slotted page tuple store.
// Sequences each request through slot read, execute, page read and result; depends on spts_pkg.
module spts_ctrl
	import spts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output spts_cmd_t cmd
);

	spts_state_t state_q, state_d;
	logic        rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		req_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SLOT_RD;
				end
			end
			S_SLOT_RD: state_d = S_EXEC;
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_PAGE_RD;
			end
			S_PAGE_RD: state_d = S_RESULT;
			S_RESULT: begin
				// hold the result until the output register frees up
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### hdl/spts_dpath.sv
// Datapath of the slotted page tuple store.
// Holds page pointers, slot table and page memories and the output register; depends on spts_pkg.
module spts_dpath
	import spts_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_SLOTS  = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  spts_cmd_t cmd,
	input  spts_req_t req_data,
	input  logic      cfg_write,
	input  logic [12:0] cfg_data,
	output spts_rsp_t rsp_data
);

	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int PW = $clog2(PAGE_BYTES);
	localparam int EFF_RST = (PAGE_LIMIT_RESET > PAGE_BYTES) ? PAGE_BYTES : PAGE_LIMIT_RESET;
	localparam int FE_RST  = (EFF_RST >= TAIL_BYTES) ? EFF_RST - TAIL_BYTES : 0;

	// configuration and page pointers
	logic [12:0]   page_lim_q;
	logic [12:0]   free_begin_q, free_end_q;
	logic [CW-1:0] tuple_count_q;
	logic          newest_valid_q;

	// captured request
	logic [2:0]  op_q;
	logic [7:0]  slot_index_q;
	logic [11:0] tuple_length_q;
	logic [11:0] byte_index_q;
	logic [7:0]  data_byte_q;

	// memories and their registered read data
	logic [24:0] slot_info_mem [MAX_SLOTS];
	logic        slot_del_mem  [MAX_SLOTS];
	logic [7:0]  page_mem      [PAGE_BYTES];
	logic [12:0] rd_off_q;
	logic [11:0] rd_len_q;
	logic        rd_del_q;
	logic [7:0]  page_rd_q;

	// execute results
	logic [1:0]    ex_status_q;
	logic [7:0]    ex_slot_q;
	logic [11:0]   ex_len_q;
	logic          ex_byte_en_q;
	logic [PW-1:0] page_addr_q;
	spts_rsp_t     rsp_q;

	logic [12:0]   idx13, cnt13, newest13, rd_addr13, gap;
	logic [SW-1:0] slot_rd_addr, slot_wr_addr;
	logic [13:0]   need;
	logic [16:0]   page_sum, eff;
	logic [12:0]   init_fe;
	logic          slot_full, no_room, byte_ok, in_page;
	logic [1:0]    res_status;
	logic [7:0]    res_slot;
	logic [11:0]   res_len;
	logic          res_byte_en;
	logic [12:0]   nx_fb, nx_fe;
	logic [CW-1:0] nx_cnt;
	logic          nx_newest, slot_we, del_we, del_wdata, page_we;

	always_comb begin
		idx13     = {5'd0, slot_index_q};
		cnt13     = 13'(tuple_count_q);
		newest13  = (cnt13 == 13'd0) ? 13'd0 : cnt13 - 13'd1;
		rd_addr13 = (op_q == OP_PUT_BYTE) ? newest13 : idx13;
		slot_rd_addr = rd_addr13[SW-1:0];
		slot_wr_addr = (op_q == OP_PUT_START) ? tuple_count_q[SW-1:0] : idx13[SW-1:0];
		gap       = (free_end_q > free_begin_q) ? free_end_q - free_begin_q : 13'd0;
		need      = {2'd0, tuple_length_q} + 14'(SLOT_BYTES);
		no_room   = {1'b0, gap} < need;
		slot_full = tuple_count_q >= CW'(MAX_SLOTS);
		page_sum  = 17'(rd_off_q) + 17'(byte_index_q);
		in_page   = page_sum < 17'(PAGE_BYTES);
		byte_ok   = byte_index_q < rd_len_q;
		eff       = ({4'd0, page_lim_q} > 17'(PAGE_BYTES)) ? 17'(PAGE_BYTES)
			: {4'd0, page_lim_q};
		init_fe   = (eff >= 17'(TAIL_BYTES)) ? 13'(eff - 17'(TAIL_BYTES)) : 13'd0;
	end

	always_comb begin
		res_status  = STAT_OK;
		res_slot    = '0;
		res_len     = '0;
		res_byte_en = 1'b0;
		nx_fb       = free_begin_q;
		nx_fe       = free_end_q;
		nx_cnt      = tuple_count_q;
		nx_newest   = newest_valid_q;
		slot_we     = 1'b0;
		del_we      = 1'b0;
		del_wdata   = 1'b0;
		page_we     = 1'b0;
		unique case (op_q)
			OP_INIT: begin
				nx_fb     = 13'(HEAD_BYTES);
				nx_fe     = init_fe;
				nx_cnt    = '0;
				nx_newest = 1'b0;
			end
			OP_PUT_START: begin
				if (tuple_length_q == 12'd0) begin
					res_status = STAT_BADLEN;
				end else if (slot_full || no_room) begin
					res_status = STAT_NOSPACE;
				end else begin
					res_slot  = cnt13[7:0];
					nx_fb     = free_begin_q + 13'(SLOT_BYTES);
					nx_fe     = free_end_q - {1'b0, tuple_length_q};
					nx_cnt    = tuple_count_q + CW'(1);
					nx_newest = 1'b1;
					slot_we   = 1'b1;
					del_we    = 1'b1;
				end
			end
			OP_PUT_BYTE: begin
				if (!newest_valid_q || cnt13 == 13'd0 || rd_del_q)
					res_status = STAT_BADSLOT;
				else if (!byte_ok)
					res_status = STAT_BADLEN;
				else
					page_we = in_page;
			end
			OP_GET: begin
				if (idx13 >= cnt13 || rd_del_q) begin
					res_status = STAT_BADSLOT;
				end else begin
					res_len = rd_len_q;
					if (!byte_ok)
						res_status = STAT_BADLEN;
					else
						res_byte_en = in_page;
				end
			end
			OP_REMOVE: begin
				if (idx13 >= cnt13) begin
					res_status = STAT_BADSLOT;
				end else begin
					del_we    = 1'b1;
					del_wdata = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_lim_q     <= 13'(PAGE_LIMIT_RESET);
			free_begin_q   <= 13'(HEAD_BYTES);
			free_end_q     <= 13'(FE_RST);
			tuple_count_q  <= '0;
			newest_valid_q <= 1'b0;
		end else begin
			if (cfg_write)
				page_lim_q <= cfg_data;
			if (cmd.exec) begin
				free_begin_q   <= nx_fb;
				free_end_q     <= nx_fe;
				tuple_count_q  <= nx_cnt;
				newest_valid_q <= nx_newest;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q           <= req_data.operation;
			slot_index_q   <= req_data.slot_index;
			tuple_length_q <= req_data.tuple_length;
			byte_index_q   <= req_data.byte_index;
			data_byte_q    <= req_data.data_byte;
		end
		if (cmd.exec) begin
			ex_status_q  <= res_status;
			ex_slot_q    <= res_slot;
			ex_len_q     <= res_len;
			ex_byte_en_q <= res_byte_en;
			page_addr_q  <= page_sum[PW-1:0];
		end
		if (cmd.load_out) begin
			rsp_q.status      <= ex_status_q;
			rsp_q.slot_number <= ex_slot_q;
			rsp_q.length_out  <= ex_len_q;
			rsp_q.byte_out    <= ex_byte_en_q ? page_rd_q : 8'd0;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (cmd.exec && slot_we)
			slot_info_mem[slot_wr_addr] <= {nx_fe, tuple_length_q};
		{rd_off_q, rd_len_q} <= slot_info_mem[slot_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && del_we)
			slot_del_mem[slot_wr_addr] <= del_wdata;
		rd_del_q <= slot_del_mem[slot_rd_addr];
	end

	// tuple bytes
	always_ff @(posedge clk) begin
		if (cmd.exec && page_we)
			page_mem[page_sum[PW-1:0]] <= data_byte_q;
		page_rd_q <= page_mem[page_addr_q];
	end

	assign rsp_data = rsp_q;

endmodule

### hdl/slotted_page_tuple_store.sv
// Slotted page tuple store, top level. A request walks the controller states slot table
// read, execute, page memory read and result load before its response is valid; a new
// request is taken only once the previous one has loaded its result.
// Reset: empty page with page limit 4096; slot table and page memory are not cleared,
// so no clearing pass is needed and requests are taken right after reset.
// Depends on spts_pkg, spts_req_if, spts_rsp_if, spts_ctrl and spts_dpath.
module slotted_page_tuple_store
	import spts_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_SLOTS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	spts_req_if.sink    req,
	spts_rsp_if.source  rsp,
	input  logic        cfg_write,
	input  logic [12:0] cfg_data
);

	// Commands from the controller drive the datapath updates of each request:
	// capture latches the request, exec commits pointers and memory writes,
	// load_out fills the output register, which parts the two channels so
	// a new request transaction can start while a response still waits.
	spts_cmd_t cmd;

	spts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	// The datapath owns the page pointers, the slot table (offset, length,
	// deleted flag) and the byte memory; the page limit register takes effect
	// at the next init.
	spts_dpath #(
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_SLOTS  (MAX_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req.data),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.rsp_data  (rsp.data)
	);

endmodule

### sim/slotted_page_tuple_store_tb.sv
// Self-checking testbench for the slotted page tuple store.
// Drives request transactions, predicts each response from a page model kept here,
// and checks responses field by field. Depends on spts_pkg, spts_req_if, spts_rsp_if
// and the slotted_page_tuple_store RTL.
module slotted_page_tuple_store_tb;
	import spts_pkg::*;

	localparam int PAGE_CAP = 4096;
	localparam int SLOT_CAP = 256;
	localparam int LATENCY = 5;
	localparam int TIMEOUT_UNITS = 20000000;
	localparam int PHASES = 7;

	// Operation codes the block has no name for; it must ignore them.
	localparam logic [2:0] OP_RSVD_LO = 3'd5;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;

	// One planned request together with the response it must produce.
	typedef struct {
		spts_req_t cmd;
		spts_rsp_t answer;
	} page_job_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [12:0] cfg_data;

	spts_req_if req_ch ();
	spts_rsp_if rsp_ch ();

	slotted_page_tuple_store #(
		.PAGE_BYTES(PAGE_CAP),
		.MAX_SLOTS(SLOT_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	// Page model: pointers, slot table and byte store; the pointers at the block's widths.
	logic [12:0] page_limit;
	logic [12:0] free_lo;
	logic [12:0] free_hi;
	logic [8:0]  n_tuples;
	logic [12:0] data_total;
	logic        open_tuple;
	logic [11:0] slot_off [SLOT_CAP];
	logic [11:0] slot_len [SLOT_CAP];
	logic        slot_gone [SLOT_CAP];
	logic [7:0]  page_mem [PAGE_CAP];
	bit          mem_known [PAGE_CAP];

	// Requests waiting for the driver, and responses owed by the block.
	page_job_t cmd_backlog [$];
	spts_rsp_t answers_due [$];

	int  n_errors = 0;
	int  n_planned = 0;
	int  n_drains = 0;
	int  rsp_count = 0;
	int  stat_seen [4] = '{0, 0, 0, 0};
	bit  steady_phase = 1'b0;
	int  send_wait = 0;
	int  send_calm = 0;
	int  take_wait = 0;
	int  take_calm = 0;
	spts_rsp_t seen_want;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_UNITS);
		$display("Verification failed");
		$finish;
	end

	task automatic report(string field, int want, int got);
		n_errors++;
		if (n_errors <= 30)
			$display("MISMATCH response %0d %s: expected %0d got %0d", rsp_count, field, want, got);
	endtask

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int pick_gap(bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(4, 1);
		return $urandom_range(40, 10);
	endfunction

	// Empty the page; page_limit takes effect here and nowhere else.
	function automatic void clear_page();
		logic [12:0] eff;
		eff = (page_limit > 13'(PAGE_CAP)) ? 13'(PAGE_CAP) : page_limit;
		free_lo = 13'(HEAD_BYTES);
		free_hi = (eff >= 13'(TAIL_BYTES)) ? eff - 13'(TAIL_BYTES) : 13'd0;
		n_tuples = '0;
		data_total = '0;
		open_tuple = 1'b0;
	endfunction

	function automatic spts_req_t rand_fields();
		spts_req_t r;
		r.operation = 3'($urandom);
		r.slot_index = 8'($urandom);
		r.tuple_length = 12'($urandom);
		r.byte_index = 12'($urandom);
		r.data_byte = 8'($urandom);
		return r;
	endfunction

	// Predict the response of one request, update the page model and queue both.
	// A get that would land on a byte never written is steered past the tuple end,
	// since storage that was never written has no defined content.
	function automatic spts_rsp_t predict_page_op(spts_req_t r);
		page_job_t job;
		spts_rsp_t o;
		logic [12:0] gap;
		logic [7:0] newest;
		logic [11:0] spot;
		if (r.operation == OP_GET && r.slot_index < n_tuples && !slot_gone[r.slot_index] &&
		    r.byte_index < slot_len[r.slot_index]) begin
			spot = slot_off[r.slot_index] + r.byte_index;
			if (!mem_known[spot])
				r.byte_index = 12'($urandom_range(4095, slot_len[r.slot_index]));
		end
		o = '0;
		case (r.operation)
			OP_INIT: clear_page();
			OP_PUT_START: begin
				gap = (free_hi > free_lo) ? free_hi - free_lo : 13'd0;
				if (r.tuple_length == '0) begin
					o.status = STAT_BADLEN;
				end else if (n_tuples >= 9'(SLOT_CAP) ||
				             gap < {1'b0, r.tuple_length} + 13'(SLOT_BYTES)) begin
					o.status = STAT_NOSPACE;
				end else begin
					o.slot_number = n_tuples[7:0];
					free_lo = free_lo + 13'(SLOT_BYTES);
					free_hi = free_hi - {1'b0, r.tuple_length};
					slot_len[n_tuples[7:0]] = r.tuple_length;
					slot_off[n_tuples[7:0]] = free_hi[11:0];
					slot_gone[n_tuples[7:0]] = 1'b0;
					n_tuples = n_tuples + 9'd1;
					data_total = data_total + {1'b0, r.tuple_length};
					open_tuple = 1'b1;
				end
			end
			OP_PUT_BYTE: begin
				newest = 8'(n_tuples - 9'd1);
				if (!open_tuple || n_tuples == '0 || slot_gone[newest]) begin
					o.status = STAT_BADSLOT;
				end else if (r.byte_index >= slot_len[newest]) begin
					o.status = STAT_BADLEN;
				end else begin
					spot = slot_off[newest] + r.byte_index;
					page_mem[spot] = r.data_byte;
					mem_known[spot] = 1'b1;
				end
			end
			OP_GET: begin
				if (r.slot_index >= n_tuples || slot_gone[r.slot_index]) begin
					o.status = STAT_BADSLOT;
				end else begin
					o.length_out = slot_len[r.slot_index];
					if (r.byte_index >= slot_len[r.slot_index])
						o.status = STAT_BADLEN;
					else
						o.byte_out = page_mem[slot_off[r.slot_index] + r.byte_index];
				end
			end
			OP_REMOVE: begin
				if (r.slot_index >= n_tuples)
					o.status = STAT_BADSLOT;
				else
					slot_gone[r.slot_index] = 1'b1;
			end
			default: ;
		endcase
		job.cmd = r;
		job.answer = o;
		cmd_backlog.push_back(job);
		n_planned++;
		return o;
	endfunction

	function automatic spts_rsp_t plan_fields(logic [2:0] op, int slot, int len, int bidx,
	                                          int data);
		spts_req_t r;
		r.operation = op;
		r.slot_index = 8'(slot);
		r.tuple_length = 12'(len);
		r.byte_index = 12'(bidx);
		r.data_byte = 8'(data);
		return predict_page_op(r);
	endfunction

	// Hold until every request is taken and every response is back.
	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || answers_due.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: hold valid and payload until the transaction completes,
	// then insert a random gap before the next one. Record the owed response
	// at the moment of acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			send_wait = 0;
			send_calm = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				answers_due.push_back(cmd_backlog[0].answer);
				void'(cmd_backlog.pop_front());
				// Now and then run a stretch of requests with no gaps at all.
				if (send_calm > 0)
					send_calm--;
				else if ($urandom_range(39) == 0)
					send_calm = $urandom_range(40, 10);
				send_wait = pick_gap(steady_phase || send_calm > 0);
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (send_wait > 0) begin
					send_wait--;
					req_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= cmd_backlog[0].cmd;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare each completed transaction with the oldest owed
	// response, and stall ready at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			take_wait = 0;
			take_calm = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_count++;
				stat_seen[rsp_ch.data.status]++;
				if (take_calm > 0)
					take_calm--;
				else if ($urandom_range(39) == 0)
					take_calm = $urandom_range(40, 10);
				if (answers_due.size() == 0) begin
					report("status with nothing owed", -1, rsp_ch.data.status);
				end else begin
					seen_want = answers_due.pop_front();
					if (rsp_ch.data.status != seen_want.status)
						report("status", seen_want.status, rsp_ch.data.status);
					if (rsp_ch.data.slot_number != seen_want.slot_number)
						report("slot_number", seen_want.slot_number, rsp_ch.data.slot_number);
					if (rsp_ch.data.length_out != seen_want.length_out)
						report("length_out", seen_want.length_out, rsp_ch.data.length_out);
					if (rsp_ch.data.byte_out != seen_want.byte_out)
						report("byte_out", seen_want.byte_out, rsp_ch.data.byte_out);
				end
			end
			if (take_wait > 0) begin
				take_wait--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(3) == 0)
					take_wait = pick_gap(steady_phase || take_calm > 0);
			end
		end
	end

	// Stimulus: reset, a directed pass over the corner cases, then random phases
	// at several page sizes with the register written only while the block is idle.
	initial begin
		spts_req_t r;
		spts_rsp_t got;
		int page_plan [PHASES];
		int budget [PHASES];
		int ph;
		int stop_at;
		int pick;
		int len;
		int k;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		page_limit = 13'(PAGE_LIMIT_RESET);
		clear_page();
		for (k = 0; k < PAGE_CAP; k++) begin
			page_mem[k] = '0;
			mem_known[k] = 1'b0;
		end
		page_plan = '{4096, 128, 8191, 2, 1000, 0, 4096};
		page_plan[5] = $urandom_range(4096, 128);
		budget = '{200, 150, 180, 40, 180, 180, 170};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty page, bad lengths, a tiny tuple, removal, a huge tuple.
		void'(plan_fields(OP_GET, 0, 0, 0, 0));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 0, 8'h5A));
		void'(plan_fields(OP_REMOVE, 0, 0, 0, 0));
		void'(plan_fields(OP_PUT_START, 0, 0, 0, 0));
		void'(plan_fields(OP_PUT_START, 255, 4095, 4095, 255));
		void'(plan_fields(OP_PUT_START, 0, 3, 0, 0));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 0, 8'h00));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 1, 8'hFF));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 2, 8'hA5));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 3, 8'h11));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 4095, 8'hFF));
		void'(plan_fields(OP_GET, 0, 0, 0, 0));
		void'(plan_fields(OP_GET, 0, 0, 2, 0));
		void'(plan_fields(OP_GET, 0, 0, 4095, 0));
		void'(plan_fields(OP_GET, 255, 0, 0, 0));
		void'(plan_fields(OP_REMOVE, 255, 0, 0, 0));
		void'(plan_fields(OP_REMOVE, 0, 0, 0, 0));
		void'(plan_fields(OP_REMOVE, 0, 0, 0, 0));
		void'(plan_fields(OP_GET, 0, 0, 1, 0));
		void'(plan_fields(OP_PUT_BYTE, 0, 0, 0, 8'h33));
		// Largest tuple that still fits after the first one, then nothing fits.
		void'(plan_fields(OP_PUT_START, 0, 3993, 0, 0));
		void'(plan_fields(OP_PUT_START, 0, 1, 0, 0));
		void'(plan_fields(OP_RSVD_LO, 255, 4095, 4095, 255));
		void'(plan_fields(OP_RSVD_HI, 255, 4095, 4095, 255));
		void'(plan_fields(OP_INIT, 0, 0, 0, 0));

		for (ph = 0; ph < PHASES; ph++) begin
			// Drain, let the pipeline settle, then rewrite the page size.
			wait_idle();
			repeat (LATENCY) @(posedge clk);
			cfg_write <= 1'b1;
			cfg_data <= 13'(page_plan[ph]);
			@(posedge clk);
			cfg_write <= 1'b0;
			page_limit = 13'(page_plan[ph]);
			steady_phase = (ph == 4);
			@(negedge clk);

			// The new size must not show until the next init.
			void'(plan_fields(OP_PUT_START, 0, 1, 0, 0));
			void'(plan_fields(OP_INIT, 0, 0, 0, 0));

			stop_at = n_planned + budget[ph];
			while (n_planned < stop_at) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					// Build a tuple: reserve it, then fill its bytes.
					len = ($urandom_range(7) == 0) ? $urandom_range(4095, 1) : $urandom_range(24, 1);
					r = rand_fields();
					r.operation = OP_PUT_START;
					r.tuple_length = 12'(len);
					got = predict_page_op(r);
					if (got.status == STAT_OK) begin
						for (k = 0; k < len; k++) begin
							if ((len <= 32 || k < 6 || k >= len - 6) && $urandom_range(19) != 0) begin
								r = rand_fields();
								r.operation = OP_PUT_BYTE;
								r.byte_index = 12'(k);
								void'(predict_page_op(r));
							end
						end
						if ($urandom_range(4) == 0) begin
							r = rand_fields();
							r.operation = OP_PUT_BYTE;
							r.byte_index = 12'($urandom_range(4095, len));
							void'(predict_page_op(r));
						end
					end else if (got.status == STAT_NOSPACE && $urandom_range(9) < 3) begin
						void'(plan_fields(OP_INIT, 0, 0, 0, 0));
					end
				end else if (pick < 80) begin
					// Read back a few bytes, mostly from live tuples.
					repeat ($urandom_range(4, 1)) begin
						r = rand_fields();
						r.operation = OP_GET;
						if (n_tuples != '0 && $urandom_range(7) != 0) begin
							r.slot_index = 8'($urandom_range(n_tuples - 9'd1));
							r.byte_index = 12'($urandom_range(slot_len[r.slot_index] - 12'd1));
						end
						void'(predict_page_op(r));
					end
				end else if (pick < 86) begin
					// Remove a slot, often the newest one.
					r = rand_fields();
					r.operation = OP_REMOVE;
					if (n_tuples != '0 && $urandom_range(2) == 0)
						r.slot_index = 8'(n_tuples - 9'd1);
					else
						r.slot_index = 8'($urandom_range(n_tuples));
					void'(predict_page_op(r));
				end else if (pick < 88) begin
					void'(plan_fields(OP_INIT, 0, 0, 0, 0));
				end else if (pick < 89) begin
					// Hold the sender until every response is back.
					wait_idle();
					n_drains++;
				end else begin
					// Noise: any operation code, any field values.
					r = rand_fields();
					r.operation = 3'($urandom_range(OP_RSVD_HI, OP_INIT));
					void'(predict_page_op(r));
				end
			end
		end

		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);
		$display("Ran %0d requests over %0d page sizes, %0d mid-run drains of the sender.",
		         n_planned, PHASES + 1, n_drains);
		$display("Response mix: ok %0d, no space %0d, bad slot %0d, bad length or index %0d.",
		         stat_seen[STAT_OK], stat_seen[STAT_NOSPACE], stat_seen[STAT_BADSLOT],
		         stat_seen[STAT_BADLEN]);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
